[rtl/igd_pkg.sv]
// Shared types and constants for the accelerometer gesture detector.
// No dependencies; used by the interfaces and every module under rtl.
package igd_pkg;

   localparam int AccelW   = 16;
   localparam int TimeW    = 32;
   localparam int GestW    = 3;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   localparam logic [GestW-1:0] GEST_NONE   = 3'd0;
   localparam logic [GestW-1:0] GEST_TAP    = 3'd1;
   localparam logic [GestW-1:0] GEST_DOUBLE = 3'd2;
   localparam logic [GestW-1:0] GEST_FLIP   = 3'd3;
   localparam logic [GestW-1:0] GEST_SHAKE  = 3'd4;

   localparam logic [CsrIdxW-1:0] REG_TAP_THRESHOLD   = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_SHAKE_THRESHOLD = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_SHAKE_DURATION  = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_FLIP_PITCH      = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_DOUBLE_TAP_GAP  = 3'd4;

   localparam logic [15:0] RST_TAP_THRESHOLD   = 16'd2000;
   localparam logic [15:0] RST_SHAKE_THRESHOLD = 16'd1500;
   localparam logic [31:0] RST_SHAKE_DURATION  = 32'd500;
   localparam logic [15:0] RST_FLIP_PITCH      = 16'd90;
   localparam logic [31:0] RST_DOUBLE_TAP_GAP  = 32'd300;

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_SPIKE = 2'd1;
   localparam logic [1:0] PHASE_WAIT  = 2'd2;

   localparam logic [17:0] SETTLE_MG = 18'd1200;

   localparam logic [12:0] ANGLE_SCALE = 13'd5730;
   localparam logic [6:0]  KEEP_PCT    = 7'd98;
   localparam logic [1:0]  BLEND_PCT   = 2'd2;
   localparam logic [23:0] RECIP_100   = 24'd10737419;
   localparam int          RecipShift  = 30;

   localparam int QuotW    = 28;
   localparam int RemW     = 17;
   localparam int DivSteps = QuotW;
   localparam int CntW     = 5;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic scale;
      logic mult;
      logic commit;
      logic finish;
   } igd_cmd_type;

   typedef struct packed {
      logic upd_en;
      logic out_free;
   } igd_status_type;

endpackage

[rtl/igd_if.sv]
// Handshake channels of the gesture detector: request, response and csr.
// Depends on igd_pkg.
interface igd_req_if;
   import igd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [AccelW-1:0] accel_x;
   logic signed [AccelW-1:0] accel_y;
   logic signed [AccelW-1:0] accel_z;
   logic [TimeW-1:0]         timestamp;
   modport source (output valid, mode, accel_x, accel_y, accel_z, timestamp, input ready);
   modport sink   (input valid, mode, accel_x, accel_y, accel_z, timestamp, output ready);
endinterface

interface igd_rsp_if;
   import igd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [GestW-1:0]         gesture;
   logic signed [AccelW-1:0] pitch;
   logic signed [AccelW-1:0] roll;
   modport source (output valid, gesture, pitch, roll, input ready);
   modport sink   (input valid, gesture, pitch, roll, output ready);
endinterface

interface igd_csr_if;
   import igd_pkg::*;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/imu_gesture_tap_shake_flip_detector.sv]
// Accelerometer tap, double tap, flip and shake detector with pitch/roll
// estimate. Depends on igd_pkg, igd_if, igd_ctrl and igd_datapath.
//
// Channels: req_if takes one word per sample (mode, accel_x/y/z, timestamp);
// mode 1 clears tap and shake tracking. rsp_if returns exactly one word per
// request: gesture code and the pitch and roll estimates after that request.
// csr_if writes the five threshold registers by index; it is always ready,
// and the user is to write it only while the detector is idle; the block
// itself does not enforce this. Sequence: a sample with nonzero z passes
// from acceptance through the start state, the 28-step serial restoring
// divider that runs for pitch and roll in parallel, and the blend and
// gesture stages to the response register. A clear command or a sample
// with zero z goes from idle straight to the final stage.
// One request at a time: req_if.ready is high only while idle.
// The response register holds a finished word while the receiver stalls;
// the next request is accepted and processed meanwhile, and waits in its
// final stage until the response register is free.
// Reset: synchronous, active high; thresholds return to defaults, tracking
// and estimates to zero, no response pending.
module imu_gesture_tap_shake_flip_detector (
   input  logic      clock,
   input  logic      reset,
   igd_req_if.sink   req_if,
   igd_rsp_if.source rsp_if,
   igd_csr_if.sink   csr_if
);
   import igd_pkg::*;

   igd_cmd_type    cmd;
   igd_status_type status;

   igd_ctrl u_ctrl (
      .clock,
      .reset,
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status,
      .cmd
   );

   igd_datapath u_datapath (
      .clock,
      .reset,
      .cmd,
      .status,
      .req_if,
      .rsp_if,
      .csr_if
   );
endmodule

[rtl/igd_lane.sv]
// One orientation axis: serial restoring divider for v*5730/z and the
// complementary filter blend. Depends on igd_pkg.
module igd_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  igd_pkg::igd_cmd_type          cmd,
   input  logic signed [igd_pkg::AccelW-1:0] num,
   input  logic signed [igd_pkg::AccelW-1:0] den,
   output logic signed [igd_pkg::AccelW-1:0] est
);
   import igd_pkg::*;

   logic [RemW+QuotW-1:0] rq_ff, rq_in;
   logic [AccelW-1:0]     d_ff;
   logic                  neg_ff;
   logic [22:0]           a1_ff;
   logic [16:0]           a2_ff;
   logic                  s1_ff, s2_ff;
   logic [16:0]           q1_ff, q2_ff;
   logic signed [AccelW-1:0] est_ff, est_in;

   logic [AccelW-1:0]     num_abs, den_abs, est_abs, ang_abs;
   logic [QuotW-1:0]      prod;
   logic [RemW+QuotW-1:0] sh;
   logic [RemW-1:0]       rem;
   logic [AccelW-1:0]     angle;
   logic [46:0]           p1;
   logic [40:0]           p2;
   logic [16:0]           v1, v2, sum;

   always_comb begin
      num_abs = num[AccelW-1] ? AccelW'(-num) : AccelW'(num);
      den_abs = den[AccelW-1] ? AccelW'(-den) : AccelW'(den);
      prod    = QuotW'(num_abs) * QuotW'(ANGLE_SCALE);
      sh      = {rq_ff[RemW+QuotW-2:0], 1'b0};
      rem     = sh[RemW+QuotW-1:QuotW];
      if (rem >= {1'b0, d_ff}) begin
         sh[RemW+QuotW-1:QuotW] = rem - {1'b0, d_ff};
         sh[0] = 1'b1;
      end
      rq_in = rq_ff;
      if (cmd.div_start) begin
         rq_in = {{RemW{1'b0}}, prod};
      end else if (cmd.div_step) begin
         rq_in = sh;
      end
      angle   = neg_ff ? AccelW'(~rq_ff[AccelW-1:0] + 1'b1) : rq_ff[AccelW-1:0];
      est_abs = est_ff[AccelW-1] ? AccelW'(-est_ff) : AccelW'(est_ff);
      ang_abs = angle[AccelW-1] ? AccelW'(-angle) : angle;
      p1      = 47'(a1_ff) * 47'(RECIP_100);
      p2      = 41'(a2_ff) * 41'(RECIP_100);
      v1      = s1_ff ? 17'(-q1_ff) : q1_ff;
      v2      = s2_ff ? 17'(-q2_ff) : q2_ff;
      sum     = v1 + v2;
      est_in  = cmd.commit ? sum[AccelW-1:0] : est_ff;
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in;
      if (cmd.div_start) begin
         d_ff   <= den_abs;
         neg_ff <= num[AccelW-1] ^ den[AccelW-1];
      end
      if (cmd.scale) begin
         a1_ff <= 23'(est_abs) * 23'(KEEP_PCT);
         s1_ff <= est_ff[AccelW-1];
         a2_ff <= 17'(ang_abs) * 17'(BLEND_PCT);
         s2_ff <= angle[AccelW-1];
      end
      if (cmd.mult) begin
         q1_ff <= 17'(p1 >> RecipShift);
         q2_ff <= 17'(p2 >> RecipShift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
      end else begin
         est_ff <= est_in;
      end
   end

   assign est = est_ff;
endmodule

[rtl/igd_datapath.sv]
// Datapath: sample capture, csr registers, two orientation lanes, tap and
// shake tracking and the response register. Depends on igd_pkg, igd_if, igd_lane.
module igd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  igd_pkg::igd_cmd_type     cmd,
   output igd_pkg::igd_status_type  status,
   igd_req_if.sink                  req_if,
   igd_rsp_if.source                rsp_if,
   igd_csr_if.sink                  csr_if
);
   import igd_pkg::*;

   logic                     mode_ff;
   logic signed [AccelW-1:0] x_ff, y_ff, z_ff;
   logic [TimeW-1:0]         t_ff;

   logic [15:0] tap_thr_ff, shake_thr_ff, flip_thr_ff;
   logic [31:0] shake_dur_ff, gap_ff;

   logic [1:0]       phase_ff, phase_in;
   logic [TimeW-1:0] mark_ff, mark_in;
   logic             shaking_ff, shaking_in;
   logic [TimeW-1:0] sbt_ff, sbt_in;
   logic             rsp_valid_ff;
   logic [GestW-1:0] gest_ff, gest_in;
   logic signed [AccelW-1:0] pitch, roll;
   logic signed [AccelW-1:0] pitch_ff, roll_ff;

   logic [AccelW-1:0] ax, ay, az, mx;
   logic [17:0]       mag, rest;
   logic [TimeW-1:0]  el_shake, el_tap;

   igd_lane u_pitch (.clock, .reset, .cmd, .num(y_ff), .den(z_ff), .est(pitch));
   igd_lane u_roll  (.clock, .reset, .cmd, .num(x_ff), .den(z_ff), .est(roll));

   assign csr_if.ready    = 1'b1;
   assign status.upd_en   = !req_if.mode && (req_if.accel_z != '0);
   assign status.out_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_if.mode;
         x_ff    <= req_if.accel_x;
         y_ff    <= req_if.accel_y;
         z_ff    <= req_if.accel_z;
         t_ff    <= req_if.timestamp;
      end
      if (cmd.finish) begin
         gest_ff  <= gest_in;
         pitch_ff <= pitch;
         roll_ff  <= roll;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_thr_ff   <= RST_TAP_THRESHOLD;
         shake_thr_ff <= RST_SHAKE_THRESHOLD;
         shake_dur_ff <= RST_SHAKE_DURATION;
         flip_thr_ff  <= RST_FLIP_PITCH;
         gap_ff       <= RST_DOUBLE_TAP_GAP;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_TAP_THRESHOLD:   tap_thr_ff   <= csr_if.data[15:0];
            REG_SHAKE_THRESHOLD: shake_thr_ff <= csr_if.data[15:0];
            REG_SHAKE_DURATION:  shake_dur_ff <= csr_if.data;
            REG_FLIP_PITCH:      flip_thr_ff  <= csr_if.data[15:0];
            REG_DOUBLE_TAP_GAP:  gap_ff       <= csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      ax = x_ff[AccelW-1] ? AccelW'(-x_ff) : AccelW'(x_ff);
      ay = y_ff[AccelW-1] ? AccelW'(-y_ff) : AccelW'(y_ff);
      az = z_ff[AccelW-1] ? AccelW'(-z_ff) : AccelW'(z_ff);
      mx = (ax > ay) ? ((ax > az) ? ax : az) : ((ay > az) ? ay : az);
      rest = 18'(ax) + 18'(ay) + 18'(az) - 18'(mx);
      mag  = 18'(mx) + (rest >> 2);
      el_shake = t_ff - sbt_ff;
      el_tap   = t_ff - mark_ff;

      gest_in    = GEST_NONE;
      phase_in   = phase_ff;
      mark_in    = mark_ff;
      shaking_in = shaking_ff;
      sbt_in     = sbt_ff;

      if (mode_ff) begin
         phase_in   = PHASE_IDLE;
         mark_in    = '0;
         shaking_in = 1'b0;
      end else begin
         if (ax > shake_thr_ff) begin
            if (!shaking_ff) begin
               shaking_in = 1'b1;
               sbt_in     = t_ff;
            end else if (el_shake > shake_dur_ff) begin
               gest_in    = GEST_SHAKE;
               shaking_in = 1'b0;
               phase_in   = PHASE_IDLE;
            end
         end else begin
            shaking_in = 1'b0;
         end

         case (phase_in)
            PHASE_SPIKE: begin
               if (mag < SETTLE_MG) begin
                  phase_in = PHASE_WAIT;
                  mark_in  = t_ff;
               end
            end
            PHASE_WAIT: begin
               if (mag > 18'(tap_thr_ff)) begin
                  gest_in  = (el_tap < gap_ff) ? GEST_DOUBLE : GEST_TAP;
                  phase_in = PHASE_IDLE;
               end else if (el_tap > gap_ff) begin
                  gest_in  = GEST_TAP;
                  phase_in = PHASE_IDLE;
               end
            end
            default: begin
               if ($signed(pitch) > $signed(flip_thr_ff)) begin
                  gest_in = GEST_FLIP;
               end
               phase_in = PHASE_IDLE;
               if (mag > 18'(tap_thr_ff)) begin
                  phase_in = PHASE_SPIKE;
                  mark_in  = t_ff;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         mark_ff      <= '0;
         shaking_ff   <= 1'b0;
         sbt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            phase_ff   <= phase_in;
            mark_ff    <= mark_in;
            shaking_ff <= shaking_in;
            sbt_ff     <= sbt_in;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.gesture = gest_ff;
   assign rsp_if.pitch   = pitch_ff;
   assign rsp_if.roll    = roll_ff;
endmodule

[rtl/igd_ctrl.sv]
// Controller state machine: sequences capture, division, blend and gesture
// evaluation. Depends on igd_pkg.
module igd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  igd_pkg::igd_status_type  status,
   output igd_pkg::igd_cmd_type     cmd
);
   import igd_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_DIV    = 7'b0000100,
      ST_SCALE  = 7'b0001000,
      ST_MULT   = 7'b0010000,
      ST_COMMIT = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.upd_en ? ST_START : ST_FINISH;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(DivSteps - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

[bench/tb_imu_gesture_tap_shake_flip_detector.sv]
// Self-checking bench for imu_gesture_tap_shake_flip_detector: random and directed
// samples are driven through req_if, responses are checked against a gesture predictor.
// Depends on igd_pkg, igd_if and the RTL under rtl.
module tb_imu_gesture_tap_shake_flip_detector;
   timeunit 1ns;
   timeprecision 1ps;
   import igd_pkg::*;

   typedef struct packed {
      logic [GestW-1:0]         gesture;
      logic signed [AccelW-1:0] pitch;
      logic signed [AccelW-1:0] roll;
   } gest_word_t;

   class gesture_scoreboard;
      logic [15:0] tap_thr, shake_thr;
      logic [31:0] shake_dur, dtap_gap;
      logic signed [15:0] flip_thr;
      logic [1:0]  phase;
      logic [31:0] mark_t, shake_t0;
      logic signed [15:0] pitch_est, roll_est;
      bit          shaking;
      gest_word_t  pending[$];
      int          mismatches, checked;
      int          gest_seen[8];

      function void clear_state();
         tap_thr = RST_TAP_THRESHOLD;
         shake_thr = RST_SHAKE_THRESHOLD;
         shake_dur = RST_SHAKE_DURATION;
         flip_thr = RST_FLIP_PITCH;
         dtap_gap = RST_DOUBLE_TAP_GAP;
         phase = PHASE_IDLE;
         mark_t = '0;
         shake_t0 = '0;
         pitch_est = '0;
         roll_est = '0;
         shaking = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [31:0] val);
         case (idx)
            REG_TAP_THRESHOLD: tap_thr = val[15:0];
            REG_SHAKE_THRESHOLD: shake_thr = val[15:0];
            REG_SHAKE_DURATION: shake_dur = val;
            REG_FLIP_PITCH: flip_thr = val[15:0];
            REG_DOUBLE_TAP_GAP: dtap_gap = val;
            default: ;
         endcase
      endfunction

      function logic signed [15:0] blend(logic signed [15:0] est, logic signed [15:0] num,
                                         logic signed [15:0] z);
         longint ang, r;
         ang = (longint'(num) * 5730) / longint'(z);
         ang = longint'($signed(ang[15:0]));
         r = (longint'(est) * 98) / 100 + (ang * 2) / 100;
         return r[15:0];
      endfunction

      function void note_sample(logic mode, logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z, logic [31:0] t);
         logic [GestW-1:0] g;
         int ax, ay, az, mx, mag;
         logic [31:0] el;
         gest_word_t w;
         g = GEST_NONE;
         if (mode) begin
            phase = PHASE_IDLE;
            mark_t = '0;
            shaking = 0;
         end else begin
            ax = x < 0 ? -int'(x) : int'(x);
            ay = y < 0 ? -int'(y) : int'(y);
            az = z < 0 ? -int'(z) : int'(z);
            mx = ax > ay ? (ax > az ? ax : az) : (ay > az ? ay : az);
            mag = mx + (ax + ay + az - mx) / 4;
            if (z != 0) begin
               pitch_est = blend(pitch_est, y, z);
               roll_est = blend(roll_est, x, z);
            end
            if (ax > int'(shake_thr)) begin
               if (!shaking) begin
                  shaking = 1;
                  shake_t0 = t;
               end else if (t - shake_t0 > shake_dur) begin
                  g = GEST_SHAKE;
                  shaking = 0;
                  phase = PHASE_IDLE;
               end
            end else begin
               shaking = 0;
            end
            if (phase == PHASE_SPIKE) begin
               if (mag < 1200) begin
                  phase = PHASE_WAIT;
                  mark_t = t;
               end
            end else if (phase == PHASE_WAIT) begin
               el = t - mark_t;
               if (mag > int'(tap_thr)) begin
                  g = el < dtap_gap ? GEST_DOUBLE : GEST_TAP;
                  phase = PHASE_IDLE;
               end else if (el > dtap_gap) begin
                  g = GEST_TAP;
                  phase = PHASE_IDLE;
               end
            end else begin
               if (pitch_est > flip_thr) g = GEST_FLIP;
               phase = PHASE_IDLE;
               if (mag > int'(tap_thr)) begin
                  phase = PHASE_SPIKE;
                  mark_t = t;
               end
            end
         end
         w.gesture = g;
         w.pitch = pitch_est;
         w.roll = roll_est;
         pending.push_back(w);
      endfunction

      function void check_word(gest_word_t got);
         gest_word_t exp_w;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         exp_w = pending.pop_front();
         checked++;
         gest_seen[exp_w.gesture]++;
         if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch #%0d: expected g=%0d p=%0d r=%0d, got g=%0d p=%0d r=%0d",
                        checked, exp_w.gesture, exp_w.pitch, exp_w.roll,
                        got.gesture, got.pitch, got.roll);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #6 clock = ~clock;

   igd_req_if req_if();
   igd_rsp_if rsp_if();
   igd_csr_if csr_if();

   imu_gesture_tap_shake_flip_detector i_dut (
      .clock(clock), .reset(reset),
      .req_if(req_if.sink), .rsp_if(rsp_if.source), .csr_if(csr_if.sink)
   );

   gesture_scoreboard board = new();
   logic [31:0] now_ms;
   int idle_cycles;
   int stall_mode;
   bit pace_sender;
   int n_items, sel;

   initial begin
      req_if.valid = 0; req_if.mode = 0; req_if.accel_x = 0; req_if.accel_y = 0;
      req_if.accel_z = 0; req_if.timestamp = 0;
      csr_if.valid = 0; csr_if.index = REG_TAP_THRESHOLD; csr_if.data = 0;
      rsp_if.ready = 0;
   end

   // receiver: check on accept, stall on a pattern that changes over time
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_word({rsp_if.gesture, rsp_if.pitch, rsp_if.roll});
   end
   always @(negedge clock) begin
      int r;
      r = $urandom_range(99);
      case (stall_mode)
         0: rsp_if.ready <= 1;
         1: rsp_if.ready <= r < 70;
         2: rsp_if.ready <= r < 15;
         default: rsp_if.ready <= ($urandom_range(7) != 0);
      endcase
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_word(logic mode, logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic [31:0] t);
      int gap;
      @(negedge clock);
      if (pace_sender && $urandom_range(3) == 0) begin
         gap = $urandom_range(40);
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1;
      req_if.mode <= mode; req_if.accel_x <= x; req_if.accel_y <= y;
      req_if.accel_z <= z; req_if.timestamp <= t;
      do @(posedge clock); while (!req_if.ready);
      board.note_sample(mode, x, y, z, t);
      n_items++;
      @(negedge clock);
      req_if.valid <= 0;
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_if.valid <= 1; csr_if.index <= idx; csr_if.data <= val;
      do @(posedge clock); while (!csr_if.ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_if.valid <= 0;
   endtask

   // one tap or double tap gesture with random content
   task automatic tap_burst();
      int k;
      logic signed [15:0] big;
      now_ms += $urandom_range(1, 30);
      big = $urandom_range(1) ? 16'(6000 + $urandom_range(20000)) : -16'sd26000;
      send_word(0, big, 16'($urandom_range(300)), 16'sd1000, now_ms);
      now_ms += $urandom_range(1, 20);
      send_word(0, 16'($urandom_range(200)), 16'sd0, 16'(800 + $urandom_range(200)),
                now_ms);
      k = $urandom_range(4);
      repeat (k) begin
         now_ms += $urandom_range(1, 200);
         send_word(0, 16'($urandom_range(400)), 16'($urandom_range(400)), 16'sd1000,
                   now_ms);
      end
      now_ms += $urandom_range(1, 400);
      send_word(0, $urandom_range(1) ? 16'sd9000 : 16'sd10, 16'sd100, -16'sd1000, now_ms);
   endtask

   task automatic shake_burst();
      int k;
      k = $urandom_range(2, 8);
      repeat (k) begin
         now_ms += $urandom_range(50, 250);
         send_word(0, $urandom_range(1) ? 16'sd4000 : -16'sd4000,
                   16'($urandom_range(500)), 16'sd1000, now_ms);
      end
   endtask

   task automatic tilt_burst();
      int k;
      k = $urandom_range(5, 40);
      repeat (k) begin
         now_ms += 5;
         send_word(0, 16'($urandom_range(500)), 16'(3000 + $urandom_range(2000)),
                   16'(100 + $urandom_range(400)), now_ms);
      end
   endtask

   task automatic noise_word();
      logic [15:0] x, y, z;
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      if ($urandom_range(9) == 0) z = '0;
      now_ms += $urandom_range(1) ? $urandom_range(50) : $urandom;
      send_word($urandom_range(7) == 0, x, y, z, now_ms);
   endtask

   initial begin
      board.clear_state();
      stall_mode = 0; pace_sender = 0; now_ms = 0; idle_cycles = 0; n_items = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      repeat (3) @(negedge clock);

      // extremes, zero z, clear, timestamp wrap
      send_word(0, 16'sh7fff, 16'sh8000, 16'sh0001, 32'hffff_ff00);
      send_word(0, 16'sh8000, 16'sh7fff, 16'sh8000, 32'h0000_0010);
      send_word(0, 16'sh8000, 16'sh8000, 16'sh0000, 32'hffff_ffff);
      send_word(0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'h0);
      send_word(0, 16'sh7fff, 16'sh0, 16'shffff, 32'd600);
      send_word(1, 16'shffff, 16'shffff, 16'shffff, 32'hffff_ffff);
      send_word(0, 16'sh0, 16'sh0, 16'sh0, 32'd700);
      now_ms = 32'hffff_fe00;
      tap_burst(); tap_burst(); shake_burst(); tilt_burst();
      send_word(1, 16'sh0, 16'sh0, 16'sh0, 32'h0);
      wait_drained();

      for (int phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            1: begin
               write_csr(REG_TAP_THRESHOLD, 32'h0);
               write_csr(REG_SHAKE_THRESHOLD, 32'hffff);
               write_csr(REG_SHAKE_DURATION, 32'h0);
               write_csr(REG_FLIP_PITCH, 32'h8000);
               write_csr(REG_DOUBLE_TAP_GAP, 32'h0);
            end
            2: begin
               write_csr(REG_TAP_THRESHOLD, 32'hffff);
               write_csr(REG_SHAKE_THRESHOLD, 32'h0);
               write_csr(REG_SHAKE_DURATION, 32'hffff_ffff);
               write_csr(REG_FLIP_PITCH, 32'h7fff);
               write_csr(REG_DOUBLE_TAP_GAP, 32'hffff_ffff);
            end
            3, 4, 5: begin
               write_csr(REG_TAP_THRESHOLD, 32'(1500 + $urandom_range(3000)));
               write_csr(REG_SHAKE_THRESHOLD, 32'(1000 + $urandom_range(3000)));
               write_csr(REG_SHAKE_DURATION, 32'($urandom_range(600)));
               write_csr(REG_FLIP_PITCH, $urandom_range(1) ? 32'd40 : 32'hffff_ffe2);
               write_csr(REG_DOUBLE_TAP_GAP, 32'($urandom_range(500)));
            end
            default: ;
         endcase
         stall_mode = phase_no % 4;
         pace_sender = phase_no != 0;
         n_items = 0;
         while (n_items < 250) begin
            sel = $urandom_range(9);
            if (sel < 4) tap_burst();
            else if (sel < 6) shake_burst();
            else if (sel < 7) tilt_burst();
            else noise_word();
            if ($urandom_range(40) == 0) wait_drained();
         end
         wait_drained();
      end

      $display("checked %0d responses: none %0d, tap %0d, double %0d, flip %0d, shake %0d",
               board.checked, board.gest_seen[0], board.gest_seen[1], board.gest_seen[2],
               board.gest_seen[3], board.gest_seen[4]);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
